### rtl/dq_pkg.sv
package dq_pkg;

    localparam int KIND_W = 3;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_CLEAR      = 3'd4,
        K_QUERY      = 3'd5
    } t_kind;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // handoff from the pointer control to the output register
    typedef struct packed {
        logic             load;
        logic             err;
        logic             empty;
        logic [CNT_W-1:0] count;
    } t_dq_stat;

endpackage

### rtl/dq_ring_mem.sv
module dq_ring_mem
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/dq_ctrl.sv
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [WORD_W-1:0] i_value,
    input  logic              i_out_free,
    output logic              o_ready,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [WORD_W-1:0] o_wdata,
    output logic [AW-1:0]     o_raddr_a,
    output logic [AW-1:0]     o_raddr_b,
    output t_dq_stat          o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_err, n_err;
    logic          accept;
    logic          full;
    logic          empty;
    logic [CW+4:0] cnt_ext;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign full    = (r_cnt == FULL);
    assign empty   = (r_cnt == '0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        n_err   = r_err;
        o_we    = 1'b0;
        o_waddr = r_tail;
        o_wdata = i_value;
        if (accept) begin
            n_err = 1'b0;
            unique case (i_kind)
                K_PUSH_FRONT: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_head  = ring_prev(r_head);
                        n_cnt   = r_cnt + CW'(1);
                        o_we    = 1'b1;
                        o_waddr = ring_prev(r_head);
                    end
                end
                K_PUSH_BACK: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_tail  = ring_next(r_tail);
                        n_cnt   = r_cnt + CW'(1);
                        o_we    = 1'b1;
                        o_waddr = r_tail;
                    end
                end
                K_POP_FRONT: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_head = ring_next(r_head);
                        n_cnt  = r_cnt - CW'(1);
                    end
                end
                K_POP_BACK: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_tail = ring_prev(r_tail);
                        n_cnt  = r_cnt - CW'(1);
                    end
                end
                K_CLEAR: begin
                    n_head = '0;
                    n_tail = '0;
                    n_cnt  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err;
    end

    // pointers settle at accept, so the read in S_READ sees the new ring
    assign o_raddr_a = r_head;
    assign o_raddr_b = ring_prev(r_tail);

    assign cnt_ext      = {5'b0, r_cnt};
    assign o_stat.load  = (r_state == S_LOAD) && i_out_free;
    assign o_stat.err   = r_err;
    assign o_stat.empty = empty;
    assign o_stat.count = cnt_ext[CNT_W-1:0];

endmodule

### rtl/double_ended_queue_unit.sv
// bounded double-ended queue of signed 32-bit words held in a ring memory
//
// input channel: i_valid / o_ready with i_kind and i_value. kind selects
// push front, push back, pop front, pop back, clear or query; i_value is
// only used by the pushes. codes 6 and 7 act as query
// output channel: o_valid / i_ready, one beat per input beat, carrying
// front and back words (all ones when empty), count, empty and error flags
// a push into a full queue or a pop from an empty queue leaves the queue
// as it was and raises o_op_error
//
// for each item, the accept cycle moves the pointers and writes
// the pushed word, the next cycle reads head and back slots from the ring
// memory, and a final step loads the result register. the memory read is
// registered and follows the pointer update. o_valid rises together with
// the load of the result register; no new beat is taken before the previous
// item has loaded its result. the result register lets the next item be taken
// while a result waits; if the receiver keeps i_ready low, that next item
// holds in its final step until the result register frees
// synchronous reset empties the queue and drops any pending result; the
// ring contents are not cleared
module double_ended_queue_unit
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_back_word,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_is_empty,
    output logic                     o_op_error
);

    localparam int AW = $clog2(DEPTH);

    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    t_dq_stat          stat;
    logic              out_free;
    logic              r_out_valid;

    assign out_free = !r_out_valid || i_ready;

    dq_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .i_out_free(out_free),
        .o_ready   (o_ready),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_stat    (stat)
    );

    dq_ring_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.load) begin
            o_front_word  <= stat.empty ? EMPTY_WORD : rdata_a;
            o_back_word   <= stat.empty ? EMPTY_WORD : rdata_b;
            o_entry_count <= stat.count;
            o_is_empty    <= stat.empty;
            o_op_error    <= stat.err;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### rtl/dq_checker.sv
module dq_checker
    import dq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [KIND_W-1:0]        i_kind,
    input logic signed [WORD_W-1:0] i_value,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [WORD_W-1:0] o_front_word,
    input logic signed [WORD_W-1:0] o_back_word,
    input logic [CNT_W-1:0]         o_entry_count,
    input logic                     o_is_empty,
    input logic                     o_op_error
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_front_word)
            && $stable(o_back_word) && $stable(o_entry_count)
            && $stable(o_is_empty) && $stable(o_op_error))
        else $error("stalled result changed");

    // empty queue reads all ones with zero count
    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_entry_count == '0
            && o_front_word == EMPTY_WORD && o_back_word == EMPTY_WORD)
        else $error("empty result inconsistent");

    // the controller works on one item at a time: input closes right after a beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
